// File: design/pcbs_pkg.sv
// shared types and constants for the per-class box suppression block
package pcbs_pkg;

	localparam int unsigned CoordW = 16;
	localparam int unsigned ScoreW = 16;
	localparam int unsigned ClassW = 8;
	localparam int unsigned ThrW   = 16;
	localparam int unsigned AreaW  = 2 * CoordW;
	localparam logic [ThrW-1:0] ThrReset = 16'd29491;

	typedef struct packed {
		logic [CoordW-1:0] bottom;
		logic [CoordW-1:0] right;
		logic [CoordW-1:0] top;
		logic [CoordW-1:0] left;
	} box_t;

	typedef struct packed {
		logic [ClassW-1:0] cls;
		logic [ScoreW-1:0] score;
	} tag_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_PICK,
		ST_SUP_RD,
		ST_SUP_GEO,
		ST_SUP_MUL,
		ST_SUP_UNI,
		ST_SUP_CMP,
		ST_EMIT,
		ST_FINISH
	} state_t;

	// commands from the sequencer to the overlap unit
	typedef struct packed {
		logic geo;
		logic mul;
		logic uni;
		logic cmp;
	} iou_ctl_t;

endpackage

// File: design/pcbs_iou_unit.sv
// shared overlap unit: intersection, areas and threshold compare over four steps
module pcbs_iou_unit (
	input  logic                     clk,
	input  pcbs_pkg::iou_ctl_t       ctl,
	input  pcbs_pkg::box_t           box_a,
	input  pcbs_pkg::box_t           box_b,
	input  logic [pcbs_pkg::ThrW-1:0] thr,
	output logic                     suppress
);
	localparam int unsigned CW = pcbs_pkg::CoordW;
	localparam int unsigned AW = pcbs_pkg::AreaW;

	logic [CW-1:0] iw_q, ih_q, aw_q, ah_q, bw_q, bh_q;
	logic          pos_q;
	logic [AW-1:0] inter_q, area_a_q, area_b_q;
	logic [AW+1:0] uni_q;
	logic          sup_q;
	logic [CW-1:0] ix1, iy1, ix2, iy2;

	// intersection corners
	always_comb begin
		ix1 = (box_a.left  > box_b.left)  ? box_a.left  : box_b.left;
		iy1 = (box_a.top   > box_b.top)   ? box_a.top   : box_b.top;
		ix2 = (box_a.right < box_b.right) ? box_a.right : box_b.right;
		iy2 = (box_a.bottom < box_b.bottom) ? box_a.bottom : box_b.bottom;
	end

	// step registers
	always_ff @(posedge clk) begin
		if (ctl.geo) begin
			pos_q <= (ix2 > ix1) && (iy2 > iy1);
			iw_q  <= ix2 - ix1;
			ih_q  <= iy2 - iy1;
			aw_q  <= box_a.right - box_a.left;
			ah_q  <= box_a.bottom - box_a.top;
			bw_q  <= box_b.right - box_b.left;
			bh_q  <= box_b.bottom - box_b.top;
		end
		if (ctl.mul) begin
			inter_q  <= iw_q * ih_q;
			area_a_q <= aw_q * ah_q;
			area_b_q <= bw_q * bh_q;
		end
		if (ctl.uni) begin
			uni_q <= {2'b00, area_a_q} + {2'b00, area_b_q} - {2'b00, inter_q};
		end
		if (ctl.cmp) begin
			sup_q <= pos_q && ({2'b00, inter_q, 16'h0000} >
				({{(AW+2){1'b0}}, thr} * {16'h0000, uni_q}));
		end
	end

	assign suppress = sup_q;
endmodule

// File: design/per_class_box_suppression.sv
// top level of the per-class greedy box suppression block
// Usage: detections arrive on the in channel (in_valid/in_ready), one transfer
// each. Loading accepts detections back to back while no burst runs. The item
// with end_of_set high is stored (if room) and starts the suppression burst;
// in_ready stays low until the burst has delivered its last result.
// Per kept detection the sequencer scans all N stored entries for the best
// score (one store read per cycle), then for every entry runs the shared
// overlap unit (a store read and the geometry, multiply, union and compare
// steps per entry, plus one closing read; one read port on the box memory),
// then offers the result. Results leave on the out channel
// (out_valid/out_ready) from an output register; a stall holds the result
// and the sequencer waits. final_result marks the last kept box, dropped_any
// flags overflow in the set. Reset clears the count, flags and sequencer and
// sets iou_threshold to its default; the stores need no clearing. Writes to
// iou_threshold (cfg_we, cfg_data) take effect at once and are to be made by
// the user only while the block is idle; the block does not enforce this.
module per_class_box_suppression #(
	parameter int unsigned MAX_DETS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  det_class,
	input  logic [15:0] score,
	input  logic [15:0] box_left,
	input  logic [15:0] box_top,
	input  logic [15:0] box_right,
	input  logic [15:0] box_bottom,
	input  logic        end_of_set,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  kept_class,
	output logic [15:0] kept_score,
	output logic [15:0] kept_left,
	output logic [15:0] kept_top,
	output logic [15:0] kept_right,
	output logic [15:0] kept_bottom,
	output logic        dropped_any,
	output logic        final_result
);
	localparam int unsigned IW = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
	localparam int unsigned CW = $clog2(MAX_DETS + 1);
	localparam int unsigned ThrBits = pcbs_pkg::ThrW;

	pcbs_pkg::box_t box_mem [MAX_DETS];
	pcbs_pkg::tag_t tag_mem [MAX_DETS];

	pcbs_pkg::state_t state_q, state_d;
	logic [CW-1:0]       count_q;
	logic                ovf_q;
	logic [MAX_DETS-1:0] done_q;
	logic [ThrBits-1:0]  thr_q;
	logic [CW-1:0]       idx_q;
	logic [IW-1:0]       rd_addr;
	logic [IW-1:0]       rd_idx_q;
	logic                rd_v_q;
	pcbs_pkg::box_t      rd_box_q;
	pcbs_pkg::tag_t      rd_tag_q;
	logic                found_q;
	logic [IW-1:0]       best_q;
	pcbs_pkg::tag_t      best_tag_q;
	pcbs_pkg::box_t      best_box_q;
	pcbs_pkg::iou_ctl_t  ctl;
	logic                suppress;
	logic                suppress_n;
	logic                cmp_done_q;
	logic                in_xfer, out_xfer;

	assign in_ready = (state_q == pcbs_pkg::ST_LOAD);
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// store read address
	always_comb begin
		rd_addr = idx_q[IW-1:0];
	end

	// detection stores, one write and one registered read
	always_ff @(posedge clk) begin
		if (in_xfer && (count_q < CW'(MAX_DETS))) begin
			box_mem[count_q[IW-1:0]] <= '{bottom: box_bottom, right: box_right,
				top: box_top, left: box_left};
			tag_mem[count_q[IW-1:0]] <= '{cls: det_class, score: score};
		end
		rd_box_q <= box_mem[rd_addr];
		rd_tag_q <= tag_mem[rd_addr];
		rd_idx_q <= rd_addr;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcbs_pkg::ST_LOAD:
				if (in_xfer && end_of_set) state_d = pcbs_pkg::ST_SCAN;
			pcbs_pkg::ST_SCAN:
				if (idx_q == count_q) state_d = pcbs_pkg::ST_SCAN_WAIT;
			pcbs_pkg::ST_SCAN_WAIT:
				state_d = pcbs_pkg::ST_PICK;
			pcbs_pkg::ST_PICK:
				state_d = found_q ? pcbs_pkg::ST_SUP_RD : pcbs_pkg::ST_FINISH;
			pcbs_pkg::ST_SUP_RD:
				state_d = (idx_q == count_q) ? pcbs_pkg::ST_EMIT : pcbs_pkg::ST_SUP_GEO;
			pcbs_pkg::ST_SUP_GEO: state_d = pcbs_pkg::ST_SUP_MUL;
			pcbs_pkg::ST_SUP_MUL: state_d = pcbs_pkg::ST_SUP_UNI;
			pcbs_pkg::ST_SUP_UNI: state_d = pcbs_pkg::ST_SUP_CMP;
			pcbs_pkg::ST_SUP_CMP: state_d = pcbs_pkg::ST_SUP_RD;
			pcbs_pkg::ST_EMIT:
				if (!out_valid || out_xfer) state_d = pcbs_pkg::ST_SCAN;
			pcbs_pkg::ST_FINISH:
				if (!out_valid || out_xfer) state_d = pcbs_pkg::ST_LOAD;
			default: state_d = pcbs_pkg::ST_LOAD;
		endcase
	end

	// overlap unit commands
	always_comb begin
		ctl.geo = (state_q == pcbs_pkg::ST_SUP_GEO);
		ctl.mul = (state_q == pcbs_pkg::ST_SUP_MUL);
		ctl.uni = (state_q == pcbs_pkg::ST_SUP_UNI);
		ctl.cmp = (state_q == pcbs_pkg::ST_SUP_CMP);
	end

	pcbs_iou_unit u_iou (
		.clk      (clk),
		.ctl      (ctl),
		.box_a    (best_box_q),
		.box_b    (rd_box_q),
		.thr      (thr_q),
		.suppress (suppress)
	);

	// compare result is valid in the cycle after its command
	assign suppress_n = cmp_done_q && suppress;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cmp_done_q <= 1'b0;
		else cmp_done_q <= ctl.cmp;
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pcbs_pkg::ST_LOAD;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			done_q     <= '0;
			thr_q      <= pcbs_pkg::ThrReset;
			idx_q      <= '0;
			rd_v_q     <= 1'b0;
			found_q    <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) thr_q <= cfg_data;
			if (out_xfer && state_q != pcbs_pkg::ST_EMIT) out_valid <= 1'b0;
			rd_v_q <= (state_q == pcbs_pkg::ST_SCAN) && (idx_q != count_q);
			unique case (state_q)
				pcbs_pkg::ST_LOAD: begin
					if (in_xfer) begin
						if (count_q < CW'(MAX_DETS)) count_q <= count_q + 1'b1;
						else ovf_q <= 1'b1;
					end
					idx_q   <= '0;
					found_q <= 1'b0;
					done_q  <= '0;
				end
				pcbs_pkg::ST_SCAN, pcbs_pkg::ST_SCAN_WAIT: begin
					// pipelined max search, the registered read runs ahead of the compare
					if (state_q == pcbs_pkg::ST_SCAN && idx_q != count_q)
						idx_q <= idx_q + 1'b1;
					if (rd_v_q && !done_q[rd_idx_q] &&
						(!found_q || rd_tag_q.score > best_tag_q.score)) begin
						found_q <= 1'b1;
					end
				end
				pcbs_pkg::ST_PICK: begin
					idx_q <= '0;
					if (found_q) done_q[best_q] <= 1'b1;
				end
				pcbs_pkg::ST_SUP_RD: begin
					// verdict for the entry compared in the previous round
					if (suppress_n && !done_q[rd_idx_q] && rd_tag_q.cls == best_tag_q.cls)
						done_q[rd_idx_q] <= 1'b1;
					if (idx_q == count_q) idx_q <= '0;
				end
				pcbs_pkg::ST_SUP_CMP: begin
					idx_q <= idx_q + 1'b1;
				end
				pcbs_pkg::ST_EMIT: begin
					if (!out_valid || out_xfer) begin
						out_valid <= 1'b1;
						found_q   <= 1'b0;
						idx_q     <= '0;
					end
				end
				pcbs_pkg::ST_FINISH: begin
					if (!out_valid || out_xfer) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// best candidate payload and output registers
	always_ff @(posedge clk) begin
		if ((state_q == pcbs_pkg::ST_SCAN || state_q == pcbs_pkg::ST_SCAN_WAIT) &&
			rd_v_q && !done_q[rd_idx_q] &&
			(!found_q || rd_tag_q.score > best_tag_q.score)) begin
			best_q     <= rd_idx_q;
			best_tag_q <= rd_tag_q;
			best_box_q <= rd_box_q;
		end
		if (state_q == pcbs_pkg::ST_EMIT && (!out_valid || out_xfer)) begin
			kept_class   <= best_tag_q.cls;
			kept_score   <= best_tag_q.score;
			kept_left    <= best_box_q.left;
			kept_top     <= best_box_q.top;
			kept_right   <= best_box_q.right;
			kept_bottom  <= best_box_q.bottom;
			dropped_any  <= ovf_q;
		end
	end

	// last kept box: no undone entry remains once this one is emitted
	logic [MAX_DETS-1:0] live_mask;
	always_comb begin
		for (int k = 0; k < MAX_DETS; k++) live_mask[k] = (k < int'(count_q)) && !done_q[k];
	end
	always_ff @(posedge clk) begin
		if (state_q == pcbs_pkg::ST_EMIT && (!out_valid || out_xfer))
			final_result <= (live_mask == '0);
	end
endmodule

// File: design/pcbs_checker.sv
// port-level checks for the per-class box suppression block, bound to the top
module pcbs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic end_of_set,
	input logic out_valid,
	input logic out_ready,
	input logic final_result
);
	// no input taken while a result is on offer
	a_no_in_with_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input accepted during burst");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");

	// end of set closes the input
	a_eos_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_set |=> !in_ready) else $error("not busy");

	// nothing more is offered right after the final result
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && final_result |=> !out_valid)
		else $error("result after final");
endmodule

bind per_class_box_suppression pcbs_checker u_pcbs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.end_of_set(end_of_set), .out_valid(out_valid), .out_ready(out_ready),
	.final_result(final_result)
);
